@@ hw/rtl/lptw_pkg.sv @@
`default_nettype none

package lptw_pkg;

   // Number of rotation iterations the arctangent table supports.
   localparam int MAX_STAGES = 24;

   // Binary angles: 65536 is one full turn.
   localparam int ANGLE_WIDTH = 16;

   // The rotation angle runs at 2^32 per turn.
   localparam int Z_WIDTH = 32;

   // The gain correction is a Q30 constant.
   localparam int GAIN_WIDTH = 30;

   // Fraction bits of the rotation datapath.
   localparam int FRAC_BITS = 24;

   // Q30 times a coordinate gives Q30; dropping this many bits gives Q24.
   localparam int PRESCALE_SHIFT = 6;

   // Guard bits above the coordinate width in the rotation datapath.
   localparam int GUARD_BITS = 26;

   localparam int OUT_WIDTH = 18;

   // Longest register chain: two prescale stages, the cells, the output stage.
   localparam int MAX_LATENCY = MAX_STAGES + 3;

   localparam longint unsigned K_INF_Q30  = 64'd652032874;
   localparam longint unsigned K_TAIL_Q30 = K_INF_Q30 * 2 / 3;

   localparam logic [ANGLE_WIDTH-1:0] OFFSET_RESET = 16'd8192;
   localparam logic [ANGLE_WIDTH-1:0] EIGHTH_TURN  = 16'd8192;

   typedef logic [1:0] quadrant_type;

   localparam quadrant_type QUAD_ZERO  = 2'd0;
   localparam quadrant_type QUAD_LEFT  = 2'd1;
   localparam quadrant_type QUAD_HALF  = 2'd2;
   localparam quadrant_type QUAD_RIGHT = 2'd3;

   // atan(2^-i), scaled to 2^32 per turn.
   localparam logic [Z_WIDTH-1:0] ATAN_TABLE [MAX_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Inverse rotation gain for a finite number of iterations, in Q30.
   function automatic logic [GAIN_WIDTH-1:0] gain_q30(input int stages);
      longint unsigned g;
      g = K_INF_Q30 + (K_TAIL_Q30 >> (2 * stages));
      return g[GAIN_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lptw_ifs.sv @@
`default_nettype none

interface lptw_req_if #(
   parameter int COORD_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] robot_x;
   logic signed [COORD_WIDTH-1:0] robot_y;
   logic        [15:0]            robot_heading;

   modport source (
      output valid, point_x, point_y, robot_x, robot_y, robot_heading,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, robot_x, robot_y, robot_heading,
      output ready
   );
endinterface

interface lptw_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [17:0] world_x;
   logic signed [17:0] world_y;

   modport source (
      output valid, world_x, world_y,
      input  ready
   );
   modport sink (
      input  valid, world_x, world_y,
      output ready
   );
endinterface

interface lptw_csr_if ();
   logic        valid;
   logic        ready;
   logic [15:0] mount_angle_offset;

   modport source (
      output valid, mount_angle_offset,
      input  ready
   );
   modport sink (
      input  valid, mount_angle_offset,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/lptw_prescale.sv @@
`default_nettype none

module lptw_prescale import lptw_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int STAGES      = 16,
   parameter int XY_WIDTH    = COORD_WIDTH + GUARD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ANGLE_WIDTH-1:0]        mount_angle_offset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_point_x,
   input  logic signed [COORD_WIDTH-1:0] in_point_y,
   input  logic signed [COORD_WIDTH-1:0] in_robot_x,
   input  logic signed [COORD_WIDTH-1:0] in_robot_y,
   input  logic [ANGLE_WIDTH-1:0]        in_heading,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [XY_WIDTH-1:0]    out_x,
   output logic signed [XY_WIDTH-1:0]    out_y,
   output logic signed [Z_WIDTH-1:0]     out_z,
   output logic signed [COORD_WIDTH-1:0] out_robot_x,
   output logic signed [COORD_WIDTH-1:0] out_robot_y
);

   localparam int PROD_WIDTH = COORD_WIDTH + GAIN_WIDTH + 1;
   localparam logic signed [GAIN_WIDTH:0] GAIN = {1'b0, gain_q30(STAGES)};
   localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
      PROD_WIDTH'(1) << (PRESCALE_SHIFT - 1);

   // First stage: angle split and gain multiply.
   logic                          a_valid_ff;
   logic                          a_ready;
   logic signed [PROD_WIDTH-1:0]  prod_x_ff, prod_x_in;
   logic signed [PROD_WIDTH-1:0]  prod_y_ff, prod_y_in;
   logic signed [Z_WIDTH-1:0]     z_a_ff, z_a_in;
   quadrant_type                  quad_ff, quad_in;
   logic signed [COORD_WIDTH-1:0] rx_a_ff, ry_a_ff;
   logic [ANGLE_WIDTH-1:0]        angle;
   logic [ANGLE_WIDTH-1:0]        angle_biased;
   logic [ANGLE_WIDTH-1:0]        residual;

   // Second stage: rounding to Q24 and the exact quarter-turn rotation.
   logic                          b_valid_ff;
   logic signed [PROD_WIDTH-1:0]  sum_x, sum_y;
   logic signed [XY_WIDTH-1:0]    x0, y0;
   logic signed [XY_WIDTH-1:0]    x_b_ff, x_b_in;
   logic signed [XY_WIDTH-1:0]    y_b_ff, y_b_in;
   logic signed [Z_WIDTH-1:0]     z_b_ff;
   logic signed [COORD_WIDTH-1:0] rx_b_ff, ry_b_ff;

   assign in_ready = !a_valid_ff || a_ready;
   assign a_ready  = !b_valid_ff || out_ready;

   always_comb begin
      angle        = in_heading + mount_angle_offset;
      angle_biased = angle + EIGHTH_TURN;
      quad_in      = angle_biased[ANGLE_WIDTH-1 -: 2];
      residual     = angle - {quad_in, {(ANGLE_WIDTH - 2){1'b0}}};
      z_a_in       = {residual, {(Z_WIDTH - ANGLE_WIDTH){1'b0}}};
      prod_x_in    = in_point_x * GAIN;
      prod_y_in    = in_point_y * GAIN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         z_a_ff    <= z_a_in;
         quad_ff   <= quad_in;
         rx_a_ff   <= in_robot_x;
         ry_a_ff   <= in_robot_y;
      end
   end

   always_comb begin
      sum_x = prod_x_ff + ROUND_HALF;
      sum_y = prod_y_ff + ROUND_HALF;
      x0    = XY_WIDTH'(sum_x >>> PRESCALE_SHIFT);
      y0    = XY_WIDTH'(sum_y >>> PRESCALE_SHIFT);
      unique case (quad_ff)
         QUAD_ZERO: begin
            x_b_in = x0;
            y_b_in = y0;
         end
         QUAD_LEFT: begin
            x_b_in = -y0;
            y_b_in = x0;
         end
         QUAD_HALF: begin
            x_b_in = -x0;
            y_b_in = -y0;
         end
         QUAD_RIGHT: begin
            x_b_in = y0;
            y_b_in = -x0;
         end
         default: begin
            x_b_in = x0;
            y_b_in = y0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_ready) begin
         x_b_ff  <= x_b_in;
         y_b_ff  <= y_b_in;
         z_b_ff  <= z_a_ff;
         rx_b_ff <= rx_a_ff;
         ry_b_ff <= ry_a_ff;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_x       = x_b_ff;
   assign out_y       = y_b_ff;
   assign out_z       = z_b_ff;
   assign out_robot_x = rx_b_ff;
   assign out_robot_y = ry_b_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lptw_cordic_cell.sv @@
`default_nettype none

module lptw_cordic_cell import lptw_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int XY_WIDTH    = COORD_WIDTH + GUARD_BITS,
   parameter int STAGE_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [XY_WIDTH-1:0]    in_x,
   input  logic signed [XY_WIDTH-1:0]    in_y,
   input  logic signed [Z_WIDTH-1:0]     in_z,
   input  logic signed [COORD_WIDTH-1:0] in_robot_x,
   input  logic signed [COORD_WIDTH-1:0] in_robot_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [XY_WIDTH-1:0]    out_x,
   output logic signed [XY_WIDTH-1:0]    out_y,
   output logic signed [Z_WIDTH-1:0]     out_z,
   output logic signed [COORD_WIDTH-1:0] out_robot_x,
   output logic signed [COORD_WIDTH-1:0] out_robot_y
);

   localparam logic signed [Z_WIDTH-1:0] ATAN_STEP = signed'(ATAN_TABLE[STAGE_INDEX]);

   logic                          valid_ff;
   logic signed [XY_WIDTH-1:0]    dx, dy;
   logic signed [XY_WIDTH-1:0]    x_ff, x_in;
   logic signed [XY_WIDTH-1:0]    y_ff, y_in;
   logic signed [Z_WIDTH-1:0]     z_ff, z_in;
   logic signed [COORD_WIDTH-1:0] rx_ff, ry_ff;

   assign in_ready = !valid_ff || out_ready;

   // One micro-rotation: turn towards zero residual angle.
   always_comb begin
      dx = in_y >>> STAGE_INDEX;
      dy = in_x >>> STAGE_INDEX;
      if (!in_z[Z_WIDTH-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         rx_ff <= in_robot_x;
         ry_ff <= in_robot_y;
      end
   end

   assign out_valid   = valid_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_z       = z_ff;
   assign out_robot_x = rx_ff;
   assign out_robot_y = ry_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lptw_round.sv @@
`default_nettype none

module lptw_round import lptw_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int XY_WIDTH    = COORD_WIDTH + GUARD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [XY_WIDTH-1:0]    in_x,
   input  logic signed [XY_WIDTH-1:0]    in_y,
   input  logic signed [COORD_WIDTH-1:0] in_robot_x,
   input  logic signed [COORD_WIDTH-1:0] in_robot_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [OUT_WIDTH-1:0]   out_world_x,
   output logic signed [OUT_WIDTH-1:0]   out_world_y
);

   localparam int INT_WIDTH = XY_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH = (COORD_WIDTH + 3 > OUT_WIDTH) ? COORD_WIDTH + 3 : OUT_WIDTH;
   localparam logic signed [XY_WIDTH-1:0] ROUND_HALF = XY_WIDTH'(1) << (FRAC_BITS - 1);

   logic                          valid_ff;
   logic signed [XY_WIDTH-1:0]    x_round, y_round;
   logic signed [INT_WIDTH-1:0]   x_int, y_int;
   logic signed [SUM_WIDTH-1:0]   x_sum, y_sum;
   logic signed [OUT_WIDTH-1:0]   wx_ff, wx_in;
   logic signed [OUT_WIDTH-1:0]   wy_ff, wy_in;

   assign in_ready = !valid_ff || out_ready;

   // Round to nearest, ties up, then add the robot position; wraps to the output width.
   always_comb begin
      x_round = in_x + ROUND_HALF;
      y_round = in_y + ROUND_HALF;
      x_int   = x_round[XY_WIDTH-1:FRAC_BITS];
      y_int   = y_round[XY_WIDTH-1:FRAC_BITS];
      x_sum   = SUM_WIDTH'(x_int) + SUM_WIDTH'(in_robot_x);
      y_sum   = SUM_WIDTH'(y_int) + SUM_WIDTH'(in_robot_y);
      wx_in   = x_sum[OUT_WIDTH-1:0];
      wy_in   = y_sum[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_world_x = wx_ff;
   assign out_world_y = wy_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lidar_point_to_world_frame.sv @@
// Channel   Direction  Handshake         Payload
// req_bus   in         valid / ready     point_x, point_y, robot_x, robot_y, robot_heading
// rsp_bus   out        valid / ready     world_x, world_y
// csr_bus   in         valid / ready     mount_angle_offset (ready is always high)
//
// One request is accepted per cycle while the pipeline is not stalled; each request passes
// through the two prescale stages, one register in each of the NUM_CELLS rotation cells, where
// NUM_CELLS is ROTATION_STAGES limited to 24, and the output stage.
// Reset is synchronous and active high; it empties the pipeline and sets the mounting offset to
// one eighth of a turn.
// Every stage holds its request while the stage after it is full and stalled, so a stalled
// result only stops the requests behind it once all bubbles in the chain have been filled.
`default_nettype none

module lidar_point_to_world_frame import lptw_pkg::*; #(
   parameter int ROTATION_STAGES = 16,
   parameter int COORD_WIDTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   lptw_req_if.sink    req_bus,
   lptw_rsp_if.source  rsp_bus,
   lptw_csr_if.sink    csr_bus
);

   // Iterations beyond the size of the arctangent table are not run.
   localparam int NUM_CELLS = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;

   // The rotation datapath carries Q24 fractions with headroom for the rotation gain,
   // the quarter-turn negation and the rounding offset.
   localparam int XY_WIDTH = COORD_WIDTH + GUARD_BITS;

   // The user must write the mounting offset only while the pipeline is empty; the block does not enforce it.
   logic [ANGLE_WIDTH-1:0] offset_ff;

   // Links between the prescaler, the rotation cells and the output stage. Link 0 feeds
   // the first cell; link NUM_CELLS carries the fully rotated point.
   logic                          link_valid [NUM_CELLS+1];
   logic                          link_ready [NUM_CELLS+1];
   logic signed [XY_WIDTH-1:0]    link_x     [NUM_CELLS+1];
   logic signed [XY_WIDTH-1:0]    link_y     [NUM_CELLS+1];
   logic signed [Z_WIDTH-1:0]     link_z     [NUM_CELLS+1];
   logic signed [COORD_WIDTH-1:0] link_rx    [NUM_CELLS+1];
   logic signed [COORD_WIDTH-1:0] link_ry    [NUM_CELLS+1];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_bus.valid) begin
         offset_ff <= csr_bus.mount_angle_offset;
      end
   end

   // The prescaler adds the heading to the mounting offset, splits off a whole number of
   // quarter turns, scales the point by the inverse rotation gain and applies the
   // quarter-turn rotation exactly, so that the cells only see a residual within one
   // eighth of a turn either way.
   lptw_prescale #(
      .COORD_WIDTH (COORD_WIDTH),
      .STAGES      (NUM_CELLS),
      .XY_WIDTH    (XY_WIDTH)
   ) u_prescale (
      .clock              (clock),
      .reset              (reset),
      .mount_angle_offset (offset_ff),
      .in_valid           (req_bus.valid),
      .in_ready           (req_bus.ready),
      .in_point_x         (req_bus.point_x),
      .in_point_y         (req_bus.point_y),
      .in_robot_x         (req_bus.robot_x),
      .in_robot_y         (req_bus.robot_y),
      .in_heading         (req_bus.robot_heading),
      .out_valid          (link_valid[0]),
      .out_ready          (link_ready[0]),
      .out_x              (link_x[0]),
      .out_y              (link_y[0]),
      .out_z              (link_z[0]),
      .out_robot_x        (link_rx[0]),
      .out_robot_y        (link_ry[0])
   );

   // The row of rotation cells: cell i shifts by i and adds or subtracts the i-th arctangent,
   // and registers its result for cell i + 1.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      lptw_cordic_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .XY_WIDTH    (XY_WIDTH),
         .STAGE_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (link_valid[i]),
         .in_ready    (link_ready[i]),
         .in_x        (link_x[i]),
         .in_y        (link_y[i]),
         .in_z        (link_z[i]),
         .in_robot_x  (link_rx[i]),
         .in_robot_y  (link_ry[i]),
         .out_valid   (link_valid[i+1]),
         .out_ready   (link_ready[i+1]),
         .out_x       (link_x[i+1]),
         .out_y       (link_y[i+1]),
         .out_z       (link_z[i+1]),
         .out_robot_x (link_rx[i+1]),
         .out_robot_y (link_ry[i+1])
      );
   end

   // The last cell's residual angle is not needed any further.
   lptw_round #(
      .COORD_WIDTH (COORD_WIDTH),
      .XY_WIDTH    (XY_WIDTH)
   ) u_round (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[NUM_CELLS]),
      .in_ready    (link_ready[NUM_CELLS]),
      .in_x        (link_x[NUM_CELLS]),
      .in_y        (link_y[NUM_CELLS]),
      .in_robot_x  (link_rx[NUM_CELLS]),
      .in_robot_y  (link_ry[NUM_CELLS]),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_world_x (rsp_bus.world_x),
      .out_world_y (rsp_bus.world_y)
   );

endmodule

`default_nettype wire

@@ hw/rtl/lptw_checker.sv @@
`default_nettype none

module lptw_checker import lptw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_WIDTH-1:0] world_x,
   input logic [OUT_WIDTH-1:0] world_y
);

   localparam int CNT_WIDTH = $clog2(MAX_LATENCY + 2);

   logic                 req_take, rsp_take;
   logic [CNT_WIDTH-1:0] pending_ff, pending_in;

   assign req_take   = req_valid && req_ready;
   assign rsp_take   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + CNT_WIDTH'(req_take) - CNT_WIDTH'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result only ever leaves for a request that is still in flight.
   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result offered with no request in flight");

   // The pipeline never holds more requests than the longest possible register chain has stages.
   a_bounded_occupancy: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_WIDTH'(MAX_LATENCY))
      else $error("more requests in flight than pipeline stages");

   // Reset empties the output stage.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(world_x) && $stable(world_y))
      else $error("stalled result changed or dropped");

endmodule

bind lidar_point_to_world_frame lptw_checker u_lptw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .world_x   (rsp_bus.world_x),
   .world_y   (rsp_bus.world_y)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import lptw_pkg::*;

   // The block is built at its default sizes; the predictor below follows the same values.
   localparam int ROTATION_STAGES = 16;
   localparam int COORD_WIDTH     = 16;

   // Cycles from an accepted request to its result when nothing stalls.
   localparam int PIPE_LATENCY = ROTATION_STAGES + 3;

   // Roughly a thousand requests, each at worst waiting out a long sender gap and a long
   // receiver stall, come to well under a quarter of this.
   localparam int CYCLE_LIMIT = 600000;

   localparam int RANDOM_PHASES   = 9;
   localparam int PHASE_REQUESTS  = 105;

   typedef enum logic [1:0] {
      OP_POINT,
      OP_SET_OFFSET,
      OP_WAIT_EMPTY
   } op_kind_type;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] robot_x;
      logic signed [COORD_WIDTH-1:0] robot_y;
      logic        [ANGLE_WIDTH-1:0] robot_heading;
   } point_req_type;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] world_x;
      logic signed [OUT_WIDTH-1:0] world_y;
   } world_point_type;

   typedef struct {
      op_kind_type             kind;
      point_req_type           pt;
      logic [ANGLE_WIDTH-1:0]  offset;
   } planned_op_type;

   logic clock;
   logic reset;

   lptw_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_bus ();
   lptw_rsp_if                              rsp_bus ();
   lptw_csr_if                              csr_bus ();

   lidar_point_to_world_frame #(
      .ROTATION_STAGES (ROTATION_STAGES),
      .COORD_WIDTH     (COORD_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Work still to be offered to the block, and the world points it owes us, oldest first.
   planned_op_type  planned_ops[$];
   world_point_type pending_world_points[$];

   // Our own copy of the mounting offset register, updated when a write is accepted.
   logic [ANGLE_WIDTH-1:0] offset_model;

   point_req_type  req_in_flight;
   planned_op_type op;
   logic           launch_req;
   logic           launch_csr;
   logic           send_calm;
   logic           recv_calm;
   int             send_gap;
   int             stall_left;

   int points_planned;
   int requests_sent;
   int offset_writes;
   int results_checked;
   int mismatch_count;
   int gap_cycles;
   int stall_cycles;
   int cycle_count;

   // The transform itself: the point is scaled by the inverse rotation gain into Q24, turned
   // by an exact quarter turn, then by the residual angle through the shift-and-add stages,
   // rounded back to millimetres and finally moved by the robot position.
   function automatic world_point_type transform_to_world(input point_req_type p,
                                                          input logic [ANGLE_WIDTH-1:0] offset);
      longint                 gain;
      longint                 x;
      longint                 y;
      longint                 z;
      longint                 t;
      longint                 dx;
      longint                 dy;
      longint                 wx;
      longint                 wy;
      logic [ANGLE_WIDTH-1:0] angle;
      logic [ANGLE_WIDTH-1:0] shifted;
      logic [ANGLE_WIDTH-1:0] residual;
      quadrant_type           quadrant;
      int                     stages;
      world_point_type        w;
      stages = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;

      // The heading and offset sum wraps at one full turn.
      angle    = p.robot_heading + offset;
      shifted  = angle + EIGHTH_TURN;
      quadrant = shifted[ANGLE_WIDTH-1 -: 2];
      residual = angle - {quadrant, 14'd0};
      z        = longint'($signed(residual)) * 65536;

      gain = longint'(K_INF_Q30 + (K_TAIL_Q30 >> (2 * stages)));
      x = (longint'(p.point_x) * gain + (64'sd1 <<< (PRESCALE_SHIFT - 1))) >>> PRESCALE_SHIFT;
      y = (longint'(p.point_y) * gain + (64'sd1 <<< (PRESCALE_SHIFT - 1))) >>> PRESCALE_SHIFT;

      case (quadrant)
         QUAD_LEFT: begin
            t = x;
            x = -y;
            y = t;
         end
         QUAD_HALF: begin
            x = -x;
            y = -y;
         end
         QUAD_RIGHT: begin
            t = x;
            x = y;
            y = -t;
         end
         default: begin
         end
      endcase

      for (int i = 0; i < stages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TABLE[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TABLE[i]);
         end
      end

      // Round to nearest with ties upwards, then add the robot position.
      wx = ((x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + longint'(p.robot_x);
      wy = ((y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + longint'(p.robot_y);
      w.world_x = wx[OUT_WIDTH-1:0];
      w.world_y = wy[OUT_WIDTH-1:0];
      return w;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // Coordinates are mostly uniform, with a share near zero and at the ends of the range.
   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      logic signed [COORD_WIDTH-1:0] edges [7];
      int r;
      edges = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
      r = $urandom_range(0, 99);
      if (r < 70)
         return COORD_WIDTH'($urandom());
      else if (r < 85)
         return COORD_WIDTH'($signed($urandom_range(0, 128)) - 64);
      else
         return edges[$urandom_range(0, 6)];
   endfunction

   // Headings also gather round the quarter-turn boundaries, where the pre-rotation switches.
   function automatic logic [ANGLE_WIDTH-1:0] rand_heading();
      logic [ANGLE_WIDTH-1:0] h;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         h = ANGLE_WIDTH'($urandom());
      end else if (r < 85) begin
         h = ANGLE_WIDTH'($urandom_range(0, 3) * 16384 + 8192);
         h = h + ANGLE_WIDTH'($urandom_range(0, 6)) - 16'd3;
      end else begin
         h = {$urandom_range(0, 3) == 0 ? 2'b11 : 2'(($urandom_range(0, 3))), 14'd0};
         if ($urandom_range(0, 1) == 1)
            h = h - 16'd1;
      end
      return h;
   endfunction

   task automatic plan_point(input logic signed [COORD_WIDTH-1:0] px,
                             input logic signed [COORD_WIDTH-1:0] py,
                             input logic signed [COORD_WIDTH-1:0] rx,
                             input logic signed [COORD_WIDTH-1:0] ry,
                             input logic [ANGLE_WIDTH-1:0] heading);
      planned_op_type p;
      p.kind             = OP_POINT;
      p.pt.point_x       = px;
      p.pt.point_y       = py;
      p.pt.robot_x       = rx;
      p.pt.robot_y       = ry;
      p.pt.robot_heading = heading;
      p.offset           = '0;
      planned_ops.push_back(p);
      points_planned++;
   endtask

   // Holding back until every result is home doubles as the point at which the register
   // may safely be rewritten, so a write is always preceded by such a pause.
   task automatic plan_pause();
      planned_op_type p;
      p.kind   = OP_WAIT_EMPTY;
      p.offset = '0;
      p.pt     = '{default: '0};
      planned_ops.push_back(p);
   endtask

   task automatic plan_offset(input logic [ANGLE_WIDTH-1:0] value);
      planned_op_type p;
      plan_pause();
      p.kind   = OP_SET_OFFSET;
      p.offset = value;
      p.pt     = '{default: '0};
      planned_ops.push_back(p);
   endtask

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s", $realtime, what);
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The driver offers the planned work in order. A request or a register write that has been
   // offered stays on the bus until the block takes it; only then is the next one chosen.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_world_points.push_back(transform_to_world(req_in_flight, offset_model));
            requests_sent++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            offset_model = csr_bus.mount_angle_offset;
            offset_writes++;
         end

         if (!(req_bus.valid && !req_bus.ready) && !(csr_bus.valid && !csr_bus.ready)) begin
            launch_req = 1'b0;
            launch_csr = 1'b0;
            // Switch now and then between bursts without gaps and choppy traffic.
            if ($urandom_range(0, 199) == 0)
               send_calm = !send_calm;

            if (send_gap > 0) begin
               send_gap--;
               gap_cycles++;
            end else if (planned_ops.size() != 0) begin
               op = planned_ops[0];
               case (op.kind)
                  OP_WAIT_EMPTY: begin
                     if (pending_world_points.size() == 0)
                        void'(planned_ops.pop_front());
                  end
                  OP_SET_OFFSET: begin
                     csr_bus.mount_angle_offset <= op.offset;
                     launch_csr = 1'b1;
                     void'(planned_ops.pop_front());
                  end
                  default: begin
                     req_in_flight = op.pt;
                     req_bus.point_x       <= op.pt.point_x;
                     req_bus.point_y       <= op.pt.point_y;
                     req_bus.robot_x       <= op.pt.robot_x;
                     req_bus.robot_y       <= op.pt.robot_y;
                     req_bus.robot_heading <= op.pt.robot_heading;
                     launch_req = 1'b1;
                     void'(planned_ops.pop_front());
                     send_gap = send_calm ? 0 : pick_gap();
                  end
               endcase
            end
            req_bus.valid <= launch_req;
            csr_bus.valid <= launch_csr;
         end
      end
   end

   // The monitor checks each accepted result against the oldest world point still owed, and
   // stalls the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (pending_world_points.size() == 0) begin
               note_failure($sformatf("unexpected result x=%0d y=%0d",
                                      rsp_bus.world_x, rsp_bus.world_y));
            end else begin
               world_point_type w;
               w = pending_world_points.pop_front();
               if (rsp_bus.world_x !== w.world_x || rsp_bus.world_y !== w.world_y)
                  note_failure($sformatf("result %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                         results_checked, w.world_x, w.world_y,
                                         rsp_bus.world_x, rsp_bus.world_y));
            end
         end

         if ($urandom_range(0, 199) == 0)
            recv_calm = !recv_calm;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
            stall_cycles++;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!recv_calm && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // A runaway guard: a correct run never gets near this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, points_planned - results_checked);
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      logic [ANGLE_WIDTH-1:0] phase_offsets [RANDOM_PHASES];

      // Every input is known from the first instant, with reset held high from the start.
      reset                      = 1'b1;
      req_bus.valid              = 1'b0;
      req_bus.point_x            = '0;
      req_bus.point_y            = '0;
      req_bus.robot_x            = '0;
      req_bus.robot_y            = '0;
      req_bus.robot_heading      = '0;
      rsp_bus.ready              = 1'b0;
      csr_bus.valid              = 1'b0;
      csr_bus.mount_angle_offset = '0;
      offset_model    = OFFSET_RESET;
      send_calm       = 1'b0;
      recv_calm       = 1'b0;
      send_gap        = 0;
      stall_left      = 0;
      points_planned  = 0;
      requests_sent   = 0;
      offset_writes   = 0;
      results_checked = 0;
      mismatch_count  = 0;
      gap_cycles      = 0;
      stall_cycles    = 0;
      cycle_count     = 0;

      // Directed part under the reset offset of an eighth of a turn: the origin, each axis at
      // both ends, all fields at their extremes together, headings on both sides of the
      // pre-rotation switch at heading zero and of quarter turns of the sum, wraps included.
      plan_point(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      plan_point(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      plan_point(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      plan_point(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'd0);
      plan_point(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'd0);
      plan_point(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'd0);
      plan_point(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'd0);
      plan_point(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'd65535);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd8191);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd8192);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd24575);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd24576);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd40960);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd57343);
      plan_point(16'sd1000, -16'sd2000, 16'sd300, -16'sd400, 16'd57344);
      plan_point(16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'd49152);

      // The register at its lowest value: the four exact quarter turns.
      plan_offset(16'd0);
      plan_point(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'd0);
      plan_point(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'd16384);
      plan_point(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'd32768);
      plan_point(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'd49152);

      // At its highest value the sum wraps for almost every heading.
      plan_offset(16'd65535);
      plan_point(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'd1);
      plan_point(16'sd12345, 16'sd23456, -16'sd5000, 16'sd5000, 16'd65535);

      // Random phases, each under its own offset, with the ends of the register range, the
      // reset value and a few random settings among them. Halfway through each phase the
      // sender holds off until every result is back.
      phase_offsets = '{16'd8192, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      for (int ph = 3; ph < RANDOM_PHASES; ph++)
         phase_offsets[ph] = ANGLE_WIDTH'($urandom());
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         plan_offset(phase_offsets[ph]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n == PHASE_REQUESTS / 2)
               plan_pause();
            plan_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_heading());
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every planned request yields exactly one result, so the run is over once that many
      // results have been seen and nothing is left to offer.
      while (planned_ops.size() != 0 || results_checked < points_planned)
         @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      if (pending_world_points.size() != 0)
         note_failure($sformatf("%0d results never arrived", pending_world_points.size()));

      $display("Covered %0d point requests under %0d offset writes, %0d results checked.",
               requests_sent, offset_writes, results_checked);
      $display("Sender idled %0d cycles, receiver stalled %0d cycles, %0d failures.",
               gap_cycles, stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
